// ===== rtl/bmp24_pkg.sv =====
// Types, limits and codes shared by the 24-bit bitmap stream decoder.
`default_nettype none

package bmp24_pkg;

    localparam logic [31:0] MAX_WIDTH  = 32'd4096;
    localparam logic [31:0] MAX_HEIGHT = 32'd4096;

    localparam logic [15:0] SIG_BM     = 16'd19778;
    localparam logic [5:0]  HDR_LAST   = 6'd53;

    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_BAD_PLANE = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } byte_word_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic        last_pixel;
        logic [1:0]  status;
    } pix_word_t;

    // signed 32-bit dimension must lie in 1..limit
    function automatic logic dim_ok(input logic [31:0] v, input logic [31:0] limit);
        dim_ok = !v[31] && (v != 32'd0) && (v <= limit);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bmp24_stream_decoder.sv =====
// 24-bit bitmap stream decoder: header parse, pixel assembly, row padding skip.
// A byte accepted into the input register is processed from there, and its
// result is registered in the output register, which drives pix_valid.
// Throughput: one byte per cycle; while a result waits on pix_stall one more
// byte is taken into the input register, after that byte_stall follows pix_stall.
// Reset: asynchronous, active low; clears both valid flags and the parse state.
`default_nettype none

module bmp24_stream_decoder
    import bmp24_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_word_t byte_word,
    output logic            pix_valid,
    input  wire logic       pix_stall,
    output pix_word_t       pix_word
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    byte_word_t s1_word_reg;

    // output stage
    logic      out_valid_reg, out_valid_next;
    pix_word_t out_word_reg;

    // parse state
    logic [1:0]  phase_reg,  phase_next;
    logic [5:0]  index_reg,  index_next;
    logic [15:0] sig_reg,    sig_next;
    logic [31:0] width_reg,  width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] planes_reg, planes_next;
    logic [11:0] col_reg,    col_next;
    logic [11:0] row_reg,    row_next;
    logic [1:0]  comp_reg,   comp_next;
    logic [7:0]  blue_reg,   blue_next;
    logic [7:0]  green_reg,  green_next;
    logic [1:0]  pad_reg,    pad_next;

    logic      process_en;
    logic      byte_take;
    logic      res_valid;
    pix_word_t res;

    // state as seen by this word (start mark restarts the parse)
    logic [1:0]  c_phase;
    logic [5:0]  c_index;
    logic [15:0] c_sig;
    logic [31:0] c_width;
    logic [31:0] c_height;
    logic [15:0] c_planes;
    logic [11:0] c_col;
    logic [11:0] c_row;
    logic [1:0]  c_comp;
    logic [7:0]  c_blue;
    logic [7:0]  c_green;
    logic [1:0]  c_pad;
    logic [7:0]  b;
    logic [15:0] sig_upd;
    logic        row_end;
    logic        last;

    assign process_en = s1_valid_reg && (!out_valid_reg || !pix_stall);
    assign byte_stall = s1_valid_reg && !process_en;
    assign byte_take  = byte_valid && !byte_stall;
    assign pix_valid  = out_valid_reg;
    assign pix_word   = out_word_reg;

    always_comb
    begin
        if (byte_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (process_en)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (process_en)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && pix_stall;
        end
    end

    always_comb
    begin
        b = s1_word_reg.file_byte;
        if (s1_word_reg.start_of_file)
        begin
            c_phase  = PH_HEADER;
            c_index  = '0;
            c_sig    = '0;
            c_width  = '0;
            c_height = '0;
            c_planes = '0;
            c_col    = '0;
            c_row    = '0;
            c_comp   = '0;
            c_blue   = '0;
            c_green  = '0;
            c_pad    = '0;
        end
        else
        begin
            c_phase  = phase_reg;
            c_index  = index_reg;
            c_sig    = sig_reg;
            c_width  = width_reg;
            c_height = height_reg;
            c_planes = planes_reg;
            c_col    = col_reg;
            c_row    = row_reg;
            c_comp   = comp_reg;
            c_blue   = blue_reg;
            c_green  = green_reg;
            c_pad    = pad_reg;
        end

        phase_next  = c_phase;
        index_next  = c_index;
        sig_next    = c_sig;
        width_next  = c_width;
        height_next = c_height;
        planes_next = c_planes;
        col_next    = c_col;
        row_next    = c_row;
        comp_next   = c_comp;
        blue_next   = c_blue;
        green_next  = c_green;
        pad_next    = c_pad;

        res_valid = 1'b0;
        res       = '0;

        sig_upd = c_sig | {b, 8'd0};
        row_end = ({20'd0, c_col} + 32'd1) == c_width;
        last    = row_end && (({20'd0, c_row} + 32'd1) == c_height);

        case (c_phase)
            PH_HEADER:
            begin
                case (c_index)
                    6'd0:  sig_next[7:0]      = c_sig[7:0] | b;
                    6'd1:  sig_next           = sig_upd;
                    6'd18: width_next[7:0]    = c_width[7:0] | b;
                    6'd19: width_next[15:8]   = c_width[15:8] | b;
                    6'd20: width_next[23:16]  = c_width[23:16] | b;
                    6'd21: width_next[31:24]  = c_width[31:24] | b;
                    6'd22: height_next[7:0]   = c_height[7:0] | b;
                    6'd23: height_next[15:8]  = c_height[15:8] | b;
                    6'd24: height_next[23:16] = c_height[23:16] | b;
                    6'd25: height_next[31:24] = c_height[31:24] | b;
                    6'd26: planes_next[7:0]   = c_planes[7:0] | b;
                    6'd27: planes_next[15:8]  = c_planes[15:8] | b;
                    default: ;
                endcase

                if ((c_index == 6'd1) && (sig_upd != SIG_BM))
                begin
                    phase_next   = PH_IDLE;
                    res_valid    = 1'b1;
                    res.status   = ST_BAD_SIG;
                end
                else if (c_index == HDR_LAST)
                begin
                    index_next = '0;
                    if (c_planes != 16'd1)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_PLANE;
                    end
                    else if (!dim_ok(c_width, MAX_WIDTH) || !dim_ok(c_height, MAX_HEIGHT))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_PIXELS;
                        col_next   = '0;
                        row_next   = '0;
                        comp_next  = '0;
                        pad_next   = '0;
                    end
                end
                else
                begin
                    index_next = c_index + 6'd1;
                end
            end

            PH_PIXELS:
            begin
                if (c_pad != 2'd0)
                begin
                    pad_next = c_pad - 2'd1;
                end
                else if (c_comp == 2'd0)
                begin
                    blue_next = b;
                    comp_next = 2'd1;
                end
                else if (c_comp == 2'd1)
                begin
                    green_next = b;
                    comp_next  = 2'd2;
                end
                else
                begin
                    comp_next      = 2'd0;
                    res_valid      = 1'b1;
                    res.red        = b;
                    res.green      = c_green;
                    res.blue       = c_blue;
                    res.pixel_row  = c_height[11:0] - 12'd1 - c_row;
                    res.pixel_col  = c_col;
                    res.last_pixel = last;
                    res.status     = ST_PIXEL;
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (row_end)
                    begin
                        col_next = '0;
                        row_next = c_row + 12'd1;
                        pad_next = c_width[1:0];
                    end
                    else
                    begin
                        col_next = c_col + 12'd1;
                    end
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            index_reg     <= '0;
            sig_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            planes_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            comp_reg      <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (process_en)
            begin
                phase_reg  <= phase_next;
                index_reg  <= index_next;
                sig_reg    <= sig_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                planes_reg <= planes_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                comp_reg   <= comp_next;
                blue_reg   <= blue_next;
                green_reg  <= green_next;
                pad_reg    <= pad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            s1_word_reg <= byte_word;
        end
        if (process_en && res_valid)
        begin
            out_word_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.status != ST_PIXEL)) |->
        (out_word_reg.red == 8'd0 && out_word_reg.green == 8'd0 &&
         out_word_reg.blue == 8'd0 && out_word_reg.pixel_row == 12'd0 &&
         out_word_reg.pixel_col == 12'd0 && !out_word_reg.last_pixel))
        else $error("error word carries pixel data");

    a_pixels_dims_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |->
        (width_reg != 32'd0 && width_reg <= MAX_WIDTH &&
         height_reg != 32'd0 && height_reg <= MAX_HEIGHT))
        else $error("pixel phase with unchecked dimensions");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |->
        ({20'd0, col_reg} < width_reg && {20'd0, row_reg} < height_reg))
        else $error("column or row beyond image");

    a_pad_between_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != 2'd0 && phase_reg == PH_PIXELS) |-> (comp_reg == 2'd0))
        else $error("padding skipped inside a pixel");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (s1_valid_reg && out_valid_reg && pix_stall))
        else $error("input stalled without a blocked output");
`endif

endmodule

`default_nettype wire
